// ===== design/sbws_pkg.sv =====
// ----------------------------------------------------------------------------
// sbws_pkg
// Shared types and constants for the segwit block witness stripper.
// ----------------------------------------------------------------------------
package sbws_pkg;

  // Width of the stripped byte counter
  localparam int LenBits = 24;
  // Width of comparisons between the counter and the capacity register
  localparam int CmpBits = 33;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Result status codes
  localparam logic [1:0] StData = 2'd0;
  localparam logic [1:0] StMal  = 2'd1;
  localparam logic [1:0] StCap  = 2'd2;

  // Configuration register byte offsets
  localparam logic [2:0] AddrCapacity = 3'd0;

  // Capacity reset value
  localparam logic [23:0] CapReset = 24'hFFFFFF;

  // Per-byte request from the parser to the emitter
  typedef struct packed {
    logic [7:0] data;
    logic       emit;
    logic       mal;
    logic       last;
    logic       fin;
  } entry_t;

  // Result held in the output stage
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [23:0] len;
  } result_t;

endpackage

// ===== design/sbws_front.sv =====
// ----------------------------------------------------------------------------
// sbws_front
// Byte parser: follows the block layout and classifies each byte.
// ----------------------------------------------------------------------------
module sbws_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_block_end,
  output logic            push,
  output sbws_pkg::entry_t entry
);
  import sbws_pkg::*;

  localparam logic [4:0] PHdr   = 5'd0;
  localparam logic [4:0] PTxCnt = 5'd1;
  localparam logic [4:0] PVer   = 5'd2;
  localparam logic [4:0] PMark  = 5'd3;
  localparam logic [4:0] PFlag  = 5'd4;
  localparam logic [4:0] PNin   = 5'd5;
  localparam logic [4:0] POutpt = 5'd6;
  localparam logic [4:0] PIslen = 5'd7;
  localparam logic [4:0] PIscr  = 5'd8;
  localparam logic [4:0] PSeq   = 5'd9;
  localparam logic [4:0] PNout  = 5'd10;
  localparam logic [4:0] PVal   = 5'd11;
  localparam logic [4:0] POslen = 5'd12;
  localparam logic [4:0] POscr  = 5'd13;
  localparam logic [4:0] PWcnt  = 5'd14;
  localparam logic [4:0] PWlen  = 5'd15;
  localparam logic [4:0] PWdat  = 5'd16;
  localparam logic [4:0] PLock  = 5'd17;
  localparam logic [4:0] PDone  = 5'd18;

  logic [4:0]  phase_r, phase_nxt;
  logic [6:0]  fbc_r, fbc_nxt;
  logic [63:0] vval_r, vval_nxt;
  logic [3:0]  vleft_r, vleft_nxt;
  logic [63:0] tx_r, tx_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] list_r, list_nxt;
  logic [63:0] items_r, items_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic        segwit_r, segwit_nxt;
  logic        halt_r, halt_nxt;

  logic        emit, mal, last;
  logic        is_v;
  logic [3:0]  vleft_eff;
  logic [6:0]  fbc_eff;
  logic        vdone;
  logic [63:0] vcalc;
  logic [63:0] list_dec, items_dec, pay_dec;
  logic [6:0]  fbc_inc;
  logic        do_ei, do_ew, do_eo, do_ao;

  assign list_dec  = list_r - 64'd1;
  assign items_dec = items_r - 64'd1;
  assign pay_dec   = pay_r - 64'd1;
  assign fbc_inc   = fbc_r + 7'd1;

  // Work out the varint step for the current byte
  always_comb begin
    vleft_eff = (phase_r == PMark) ? 4'd0 : vleft_r;
    fbc_eff   = (phase_r == PMark) ? 7'd0 : fbc_r;
    if (vleft_eff == 4'd0) begin
      vdone = (in_byte < 8'hFD);
      vcalc = {56'd0, in_byte};
    end else begin
      vdone = (vleft_eff == 4'd1);
      vcalc = ((phase_r == PMark) ? 64'd0 : vval_r)
              | ({56'd0, in_byte} << {fbc_eff[2:0], 3'b000});
    end
  end

  // Advance the parse state
  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    vval_nxt   = vval_r;
    vleft_nxt  = vleft_r;
    tx_nxt     = tx_r;
    total_nxt  = total_r;
    list_nxt   = list_r;
    items_nxt  = items_r;
    pay_nxt    = pay_r;
    segwit_nxt = segwit_r;
    halt_nxt   = halt_r;
    emit       = 1'b1;
    mal        = 1'b0;
    last       = 1'b0;
    do_ei      = 1'b0;
    do_ew      = 1'b0;
    do_eo      = 1'b0;
    do_ao      = 1'b0;

    is_v = (phase_r == PTxCnt) || (phase_r == PNin) || (phase_r == PIslen) ||
           (phase_r == PNout) || (phase_r == POslen) || (phase_r == PWcnt) ||
           (phase_r == PWlen) || ((phase_r == PMark) && (in_byte != 8'h00));

    // Varint bookkeeping, overridden below when the field completes
    if (is_v) begin
      if (vleft_eff == 4'd0) begin
        if (in_byte >= 8'hFD) begin
          vleft_nxt = (in_byte == 8'hFD) ? 4'd2 : (in_byte == 8'hFE) ? 4'd4 : 4'd8;
          vval_nxt  = 64'd0;
          fbc_nxt   = 7'd0;
        end else begin
          vval_nxt  = vcalc;
          vleft_nxt = 4'd0;
          fbc_nxt   = fbc_eff;
        end
      end else begin
        vval_nxt  = vcalc;
        fbc_nxt   = fbc_eff + 7'd1;
        vleft_nxt = vleft_eff - 4'd1;
      end
    end

    unique case (phase_r)
      PHdr: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd80) begin
          phase_nxt = PTxCnt; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
        end
      end
      PTxCnt: begin
        if (vdone) begin
          if (vcalc == 64'd0) begin
            mal = 1'b1;
          end else begin
            tx_nxt = vcalc; segwit_nxt = 1'b0; phase_nxt = PVer; fbc_nxt = 7'd0;
          end
        end
      end
      PVer: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd4) phase_nxt = PMark;
      end
      PMark, PNin: begin
        if ((phase_r == PMark) && (in_byte == 8'h00)) begin
          segwit_nxt = 1'b1; emit = 1'b0; phase_nxt = PFlag;
        end else begin
          phase_nxt = PNin;
          if (vdone) begin
            if (vcalc == 64'd0) begin
              mal = 1'b1;
            end else begin
              total_nxt = vcalc; list_nxt = vcalc; phase_nxt = POutpt; fbc_nxt = 7'd0;
            end
          end
        end
      end
      PFlag: begin
        emit = 1'b0;
        if (in_byte != 8'h01) begin
          mal = 1'b1;
        end else begin
          phase_nxt = PNin; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
        end
      end
      POutpt: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd36) begin
          phase_nxt = PIslen; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
        end
      end
      PIslen: begin
        if (vdone) begin
          pay_nxt = vcalc;
          if (vcalc == 64'd0) begin
            phase_nxt = PSeq; fbc_nxt = 7'd0;
          end else begin
            phase_nxt = PIscr;
          end
        end
      end
      PIscr: begin
        pay_nxt = pay_dec;
        if (pay_dec == 64'd0) begin
          phase_nxt = PSeq; fbc_nxt = 7'd0;
        end
      end
      PSeq: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd4) begin
          list_nxt = list_dec;
          fbc_nxt  = 7'd0;
          if (list_dec == 64'd0) begin
            phase_nxt = PNout; vleft_nxt = 4'd0; vval_nxt = 64'd0;
          end else begin
            phase_nxt = POutpt;
          end
        end
      end
      PNout: begin
        if (vdone) begin
          list_nxt = vcalc;
          if (vcalc == 64'd0) begin
            do_ao = 1'b1;
          end else begin
            phase_nxt = PVal; fbc_nxt = 7'd0;
          end
        end
      end
      PVal: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd8) begin
          phase_nxt = POslen; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
        end
      end
      POslen: begin
        if (vdone) begin
          pay_nxt = vcalc;
          if (vcalc == 64'd0) do_eo = 1'b1;
          else phase_nxt = POscr;
        end
      end
      POscr: begin
        pay_nxt = pay_dec;
        if (pay_dec == 64'd0) do_eo = 1'b1;
      end
      PWcnt: begin
        emit = 1'b0;
        if (vdone) begin
          items_nxt = vcalc;
          if (vcalc == 64'd0) begin
            do_ew = 1'b1;
          end else begin
            phase_nxt = PWlen; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
          end
        end
      end
      PWlen: begin
        emit = 1'b0;
        if (vdone) begin
          pay_nxt = vcalc;
          if (vcalc == 64'd0) do_ei = 1'b1;
          else phase_nxt = PWdat;
        end
      end
      PWdat: begin
        emit    = 1'b0;
        pay_nxt = pay_dec;
        if (pay_dec == 64'd0) do_ei = 1'b1;
      end
      PLock: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 7'd4) begin
          tx_nxt = tx_r - 64'd1;
          if (tx_r == 64'd1) begin
            last = 1'b1; phase_nxt = PDone;
          end else begin
            segwit_nxt = 1'b0; phase_nxt = PVer; fbc_nxt = 7'd0;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // Close an item, a witness stack or an output
    if (do_ei) begin
      items_nxt = items_dec;
      if (items_dec == 64'd0) begin
        do_ew = 1'b1;
      end else begin
        phase_nxt = PWlen; fbc_nxt = 7'd0; vleft_nxt = 4'd0; vval_nxt = 64'd0;
      end
    end
    if (do_ew) begin
      list_nxt = list_dec;
      fbc_nxt  = 7'd0;
      if (list_dec == 64'd0) begin
        phase_nxt = PLock;
      end else begin
        phase_nxt = PWcnt; vleft_nxt = 4'd0; vval_nxt = 64'd0;
      end
    end
    if (do_eo) begin
      list_nxt = list_dec;
      if (list_dec == 64'd0) begin
        do_ao = 1'b1;
      end else begin
        phase_nxt = PVal; fbc_nxt = 7'd0;
      end
    end
    if (do_ao) begin
      fbc_nxt = 7'd0;
      if (segwit_r) begin
        list_nxt = total_r; phase_nxt = PWcnt; vleft_nxt = 4'd0; vval_nxt = 64'd0;
      end else begin
        phase_nxt = PLock;
      end
    end

    if (mal || last) halt_nxt = 1'b1;
  end

  // Hand the byte to the emitter
  assign push = accept && (halt_r ? in_block_end : (emit || mal || in_block_end));
  always_comb begin
    entry.data = in_byte;
    entry.emit = emit && !halt_r;
    entry.mal  = mal && !halt_r;
    entry.last = last && !halt_r;
    entry.fin  = in_block_end;
  end

  // Hold the parse state; clear it at block end
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_block_end)) begin
      phase_r  <= PHdr;
      fbc_r    <= 7'd0;
      vval_r   <= 64'd0;
      vleft_r  <= 4'd0;
      tx_r     <= 64'd0;
      total_r  <= 64'd0;
      list_r   <= 64'd0;
      items_r  <= 64'd0;
      pay_r    <= 64'd0;
      segwit_r <= 1'b0;
      halt_r   <= 1'b0;
    end else if (accept && !halt_r) begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      vval_r   <= vval_nxt;
      vleft_r  <= vleft_nxt;
      tx_r     <= tx_nxt;
      total_r  <= total_nxt;
      list_r   <= list_nxt;
      items_r  <= items_nxt;
      pay_r    <= pay_nxt;
      segwit_r <= segwit_nxt;
      halt_r   <= halt_nxt;
    end
  end

endmodule

// ===== design/sbws_fifo.sv =====
// ----------------------------------------------------------------------------
// sbws_fifo
// Short queue of parser requests between front and back.
// ----------------------------------------------------------------------------
module sbws_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sbws_pkg::entry_t wr_data,
  input  logic             rd_en,
  output sbws_pkg::entry_t rd_data,
  output logic             full,
  output logic             empty
);
  import sbws_pkg::*;

  entry_t             mem_r [QDepth];
  logic [QPtrW-1:0]   wp_r, rp_r;
  logic [QPtrW:0]     cnt_r;

  assign full    = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Store the request
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (!wr_en && rd_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/sbws_back.sv =====
// ----------------------------------------------------------------------------
// sbws_back
// Emitter: applies capacity and truncation checks, counts stripped bytes.
// ----------------------------------------------------------------------------
module sbws_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       capacity,
  input  sbws_pkg::entry_t  head,
  input  logic              head_empty,
  output logic              head_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output sbws_pkg::result_t res
);
  import sbws_pkg::*;

  logic [LenBits-1:0] cnt_r, cnt_nxt;
  logic               halt_r, halt_nxt;
  logic               vld_r;
  result_t            res_r, res_nxt;
  logic               produce;
  logic               room;
  logic [1:0]         err;
  logic [LenBits-1:0] cnt_inc;
  logic [CmpBits-1:0] cnt_ext, cap_ext, inc_ext;

  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_ext = CmpBits'(cnt_r);
  assign cap_ext = CmpBits'(capacity);
  assign inc_ext = CmpBits'(cnt_inc);

  // Classify the head request
  always_comb begin
    err = StData;
    if (head.mal) err = StMal;
    else if (head.emit && ((cnt_ext >= cap_ext) || (&cnt_r))) err = StCap;
    else if (head.fin && !head.last) err = StMal;
    produce  = !halt_r && ((err != StData) || head.emit);
    cnt_nxt  = cnt_r;
    halt_nxt = halt_r;
    res_nxt.data   = 8'd0;
    res_nxt.last   = 1'b0;
    res_nxt.status = err;
    res_nxt.len    = 24'd0;
    if (!halt_r) begin
      if (err != StData) begin
        halt_nxt = 1'b1;
      end else if (head.emit) begin
        cnt_nxt      = cnt_inc;
        res_nxt.data = head.data;
        res_nxt.last = head.last;
        if (head.last) begin
          res_nxt.len = inc_ext[23:0];
          halt_nxt    = 1'b1;
        end
      end
    end
    if (head.fin) begin
      cnt_nxt  = '0;
      halt_nxt = 1'b0;
    end
  end

  assign room      = !vld_r || out_pop;
  assign head_pop  = !head_empty && (!produce || room);
  assign out_empty = !vld_r;
  assign res       = res_r;

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (head_pop && produce) res_r <= res_nxt;
  end

  // Advance count, halt and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      halt_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (head_pop) begin
        cnt_r  <= cnt_nxt;
        halt_r <= halt_nxt;
      end
      if (head_pop && produce) vld_r <= 1'b1;
      else if (out_pop) vld_r <= 1'b0;
    end
  end

endmodule

// ===== design/segwit_block_witness_stripper.sv =====
// ----------------------------------------------------------------------------
// segwit_block_witness_stripper
// Streams a serialized block and emits it with marker, flag and witnesses
// removed, plus error and length reporting.
//
//   channel | ports                                   | handshake
//   input   | in_byte, in_block_end                   | in_push / in_full
//   result  | out_byte, out_last, out_status,         | out_pop / out_empty
//           | out_stripped_length                     |
//   config  | paddr, pwdata, prdata                   | psel, penable, pwrite
//
// One byte is accepted per cycle while in_full is low; its result passes the
// parser, the four-entry request queue and the output register in turn.
// Reset: synchronous, active low; clears parse state, queue and counters and
// sets the capacity register to all ones. No clearing pass.
// Stalls: in_full rises only when the request queue holds four requests,
// which happens when results are not popped.
// ----------------------------------------------------------------------------
module segwit_block_witness_stripper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_block_end,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [23:0] out_stripped_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbws_pkg::*;

  logic        accept;
  logic        push;
  entry_t      entry;
  entry_t      head;
  logic        head_empty;
  logic        head_pop;
  result_t     res;
  logic [23:0] cap_r;

  assign accept = in_push && !in_full;
  assign pready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (psel && penable && pwrite && (paddr[2] == AddrCapacity[2])) begin
      cap_r <= pwdata[23:0];
    end
  end
  assign prdata = (paddr[2] == AddrCapacity[2]) ? {8'd0, cap_r} : 32'd0;

  sbws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_block_end (in_block_end),
    .push         (push),
    .entry        (entry)
  );

  sbws_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (entry),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (in_full),
    .empty   (head_empty)
  );

  sbws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (cap_r),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .res        (res)
  );

  assign out_byte            = res.data;
  assign out_last            = res.last;
  assign out_status          = res.status;
  assign out_stripped_length = res.len;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segwit block witness stripper. Feeds whole
// blocks (well-formed segwit and legacy transactions, plus broken and noise
// blocks) byte by byte, predicts each stripped byte or status and compares
// every popped result in order. Capacity is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
  import sbws_pkg::*;

  typedef enum int {
    PhHdr, PhTxCnt, PhVer, PhMark, PhFlag, PhNin, PhOutpt, PhIslen, PhIscr,
    PhSeq, PhNout, PhVal, PhOslen, PhOscr, PhWcnt, PhWlen, PhWdat, PhLock,
    PhDone
  } phase_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [23:0] len;
  } strip_res_t;

  localparam int WatchLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_block_end;
  logic        out_pop;
  logic        out_empty;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_status;
  logic [23:0] out_stripped_length;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segwit_block_witness_stripper i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_byte             (in_byte),
    .in_block_end        (in_block_end),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_byte            (out_byte),
    .out_last            (out_last),
    .out_status          (out_status),
    .out_stripped_length (out_stripped_length),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state
  logic [23:0] cap_q;
  phase_e      ph_q;
  int unsigned fcnt_q;
  logic [63:0] vval_q;
  int unsigned vleft_q;
  logic [63:0] tx_left_q, in_total_q, list_left_q, items_left_q, pay_left_q;
  logic        segwit_q;
  logic [23:0] ocnt_q;
  logic        halted_q;

  strip_res_t  exp_q[$];
  int          n_err;
  int          idle_cnt;
  bit          stop_pop;

  // Byte stream under construction
  logic [7:0]  blk_q[$];

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    n_err++;
  endtask

  task automatic clear_block();
    ph_q = PhHdr; fcnt_q = 0; vval_q = '0; vleft_q = 0;
    tx_left_q = '0; in_total_q = '0; list_left_q = '0; items_left_q = '0;
    pay_left_q = '0; segwit_q = 1'b0; ocnt_q = '0; halted_q = 1'b0;
  endtask

  function automatic void enter_fixed(input phase_e p);
    ph_q = p; fcnt_q = 0;
  endfunction

  function automatic void enter_var(input phase_e p);
    ph_q = p; fcnt_q = 0; vleft_q = 0; vval_q = '0;
  endfunction

  function automatic bit take_var(input logic [7:0] b);
    if (vleft_q == 0) begin
      if (b < 8'hfd) begin
        vval_q = {56'd0, b};
        return 1'b1;
      end
      vleft_q = (b == 8'hfd) ? 2 : (b == 8'hfe) ? 4 : 8;
      vval_q = '0; fcnt_q = 0;
      return 1'b0;
    end
    vval_q |= {56'd0, b} << (8 * (fcnt_q & 7));
    fcnt_q++;
    vleft_q--;
    return vleft_q == 0;
  endfunction

  function automatic void after_outs();
    if (segwit_q) begin
      list_left_q = in_total_q; enter_var(PhWcnt);
    end else begin
      enter_fixed(PhLock);
    end
  endfunction

  function automatic void end_out();
    list_left_q--;
    if (list_left_q == 0) after_outs(); else enter_fixed(PhVal);
  endfunction

  function automatic void end_wit();
    list_left_q--;
    if (list_left_q == 0) enter_fixed(PhLock); else enter_var(PhWcnt);
  endfunction

  function automatic void end_itm();
    items_left_q--;
    if (items_left_q == 0) end_wit(); else enter_var(PhWlen);
  endfunction

  function automatic logic [1:0] nin_take(input logic [7:0] b);
    if (!take_var(b)) return StData;
    if (vval_q == 0) return StMal;
    in_total_q = vval_q; list_left_q = vval_q;
    enter_fixed(PhOutpt);
    return StData;
  endfunction

  // Predict the result of one accepted byte
  task automatic predict_strip(input logic [7:0] b, input logic fin);
    bit          emit, last;
    logic [1:0]  st;
    strip_res_t  r;
    emit = 1'b1; last = 1'b0; st = StData;
    if (halted_q) begin
      if (fin) clear_block();
      return;
    end
    case (ph_q)
      PhHdr: begin
        fcnt_q++;
        if (fcnt_q >= 80) enter_var(PhTxCnt);
      end
      PhTxCnt: begin
        if (take_var(b)) begin
          if (vval_q == 0) st = StMal;
          else begin
            tx_left_q = vval_q; segwit_q = 1'b0; enter_fixed(PhVer);
          end
        end
      end
      PhVer: begin
        fcnt_q++;
        if (fcnt_q >= 4) ph_q = PhMark;
      end
      PhMark: begin
        if (b == 8'h00) begin
          segwit_q = 1'b1; emit = 1'b0; ph_q = PhFlag;
        end else begin
          enter_var(PhNin); st = nin_take(b);
        end
      end
      PhFlag: begin
        emit = 1'b0;
        if (b != 8'h01) st = StMal; else enter_var(PhNin);
      end
      PhNin: st = nin_take(b);
      PhOutpt: begin
        fcnt_q++;
        if (fcnt_q >= 36) enter_var(PhIslen);
      end
      PhIslen: begin
        if (take_var(b)) begin
          pay_left_q = vval_q;
          if (pay_left_q == 0) enter_fixed(PhSeq); else ph_q = PhIscr;
        end
      end
      PhIscr: begin
        pay_left_q--;
        if (pay_left_q == 0) enter_fixed(PhSeq);
      end
      PhSeq: begin
        fcnt_q++;
        if (fcnt_q >= 4) begin
          list_left_q--;
          if (list_left_q == 0) enter_var(PhNout); else enter_fixed(PhOutpt);
        end
      end
      PhNout: begin
        if (take_var(b)) begin
          list_left_q = vval_q;
          if (list_left_q == 0) after_outs(); else enter_fixed(PhVal);
        end
      end
      PhVal: begin
        fcnt_q++;
        if (fcnt_q >= 8) enter_var(PhOslen);
      end
      PhOslen: begin
        if (take_var(b)) begin
          pay_left_q = vval_q;
          if (pay_left_q == 0) end_out(); else ph_q = PhOscr;
        end
      end
      PhOscr: begin
        pay_left_q--;
        if (pay_left_q == 0) end_out();
      end
      PhWcnt: begin
        emit = 1'b0;
        if (take_var(b)) begin
          items_left_q = vval_q;
          if (items_left_q == 0) end_wit(); else enter_var(PhWlen);
        end
      end
      PhWlen: begin
        emit = 1'b0;
        if (take_var(b)) begin
          pay_left_q = vval_q;
          if (pay_left_q == 0) end_itm(); else ph_q = PhWdat;
        end
      end
      PhWdat: begin
        emit = 1'b0;
        pay_left_q--;
        if (pay_left_q == 0) end_itm();
      end
      PhLock: begin
        fcnt_q++;
        if (fcnt_q >= 4) begin
          tx_left_q--;
          if (tx_left_q == 0) begin
            last = 1'b1; ph_q = PhDone;
          end else begin
            segwit_q = 1'b0; enter_fixed(PhVer);
          end
        end
      end
      default: emit = 1'b0;
    endcase
    if (st == StData && emit && (ocnt_q >= cap_q || ocnt_q == 24'hffffff)) st = StCap;
    if (st == StData && fin && !last) st = StMal;
    if (st != StData) begin
      halted_q = 1'b1;
      r = '{data: 8'd0, last: 1'b0, status: st, len: 24'd0};
      exp_q.push_back(r);
    end else if (emit) begin
      ocnt_q = ocnt_q + 24'd1;
      r = '{data: b, last: last, status: StData, len: last ? ocnt_q : 24'd0};
      if (last) halted_q = 1'b1;
      exp_q.push_back(r);
    end
    if (fin) clear_block();
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    strip_res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (exp_q.size() == 0) begin
        report("unexpected result", {24'd0, out_byte}, 32'd0);
      end else begin
        e = exp_q.pop_front();
        if (out_byte !== e.data) report("out_byte", {24'd0, out_byte}, {24'd0, e.data});
        if (out_last !== e.last) report("out_last", {31'd0, out_last}, {31'd0, e.last});
        if (out_status !== e.status)
          report("out_status", {30'd0, out_status}, {30'd0, e.status});
        if (out_stripped_length !== e.len)
          report("out_stripped_length", {8'd0, out_stripped_length}, {8'd0, e.len});
      end
    end
  end

  always @(negedge clk) begin
    if (stop_pop) out_pop <= 1'b0;
    else out_pop <= (($urandom_range(0, 15) < 11) || ($urandom_range(0, 63) < 2));
  end

  // Watchdog on cycles without any accepted byte or popped result
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("segwit_block_witness_stripper test failed");
      $finish;
    end
  end

  // Push one byte, holding until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_push = 1'b1;
    in_byte <= b;
    in_block_end <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_strip(b, fin);
    @(negedge clk);
  endtask

  // Stream the built block in bursts with random gaps
  task automatic send_block();
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < blk_q.size(); i++) begin
      send_byte(blk_q[i], i == blk_q.size() - 1);
      burst--;
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_push = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
    end
    in_push = 1'b0;
    blk_q.delete();
  endtask

  task automatic put_var(input logic [63:0] v, input int form);
    if (form == 0 && v < 64'hfd) blk_q.push_back(v[7:0]);
    else if (form <= 1 && v <= 64'hffff) begin
      blk_q.push_back(8'hfd);
      for (int i = 0; i < 2; i++) blk_q.push_back(v[8*i +: 8]);
    end else if (form <= 2 && v <= 64'hffffffff) begin
      blk_q.push_back(8'hfe);
      for (int i = 0; i < 4; i++) blk_q.push_back(v[8*i +: 8]);
    end else begin
      blk_q.push_back(8'hff);
      for (int i = 0; i < 8; i++) blk_q.push_back(v[8*i +: 8]);
    end
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) blk_q.push_back(8'($urandom));
  endtask

  // Build a random well-formed block
  task automatic build_block(input int ntx, input int wit_mode);
    int nin, nout, nitm, ln;
    bit sw;
    put_rand(80);
    put_var(ntx, $urandom_range(0, 3));
    for (int t = 0; t < ntx; t++) begin
      put_rand(4);
      sw = (wit_mode == 2) ? $urandom_range(0, 1) : wit_mode;
      if (sw) begin
        blk_q.push_back(8'h00); blk_q.push_back(8'h01);
      end
      nin = $urandom_range(1, 2);
      // Input count must not start with 0x00 in legacy form
      put_var(nin, $urandom_range(0, 3));
      for (int i = 0; i < nin; i++) begin
        put_rand(36);
        ln = $urandom_range(0, 5);
        put_var(ln, $urandom_range(0, 1));
        put_rand(ln);
        put_rand(4);
      end
      nout = $urandom_range(0, 2);
      put_var(nout, $urandom_range(0, 1));
      for (int o = 0; o < nout; o++) begin
        put_rand(8);
        ln = $urandom_range(0, 5);
        put_var(ln, $urandom_range(0, 1));
        put_rand(ln);
      end
      if (sw) begin
        for (int i = 0; i < nin; i++) begin
          nitm = $urandom_range(0, 2);
          put_var(nitm, $urandom_range(0, 1));
          for (int k = 0; k < nitm; k++) begin
            ln = $urandom_range(0, 4);
            put_var(ln, $urandom_range(0, 2));
            put_rand(ln);
          end
        end
      end
      put_rand(4);
    end
    if ($urandom_range(0, 3) == 0) put_rand($urandom_range(1, 3));
  endtask

  // Wait until every expected result has been popped, then settle
  task automatic drain();
    while (exp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cap(input logic [23:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrCapacity; pwdata <= {8'd0, v};
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_q = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Directed blocks: kind, tx count, witness mode
  typedef struct {
    int kind;
    int ntx;
    int wmode;
  } dir_row_t;

  localparam int KindGood  = 0;
  localparam int KindZeroTx = 1;
  localparam int KindBadFlag = 2;
  localparam int KindZeroIn = 3;
  localparam int KindTrunc = 4;
  localparam int KindShort = 5;

  dir_row_t dir_tab[7] = '{
    '{KindGood, 2, 2}, '{KindZeroTx, 0, 0}, '{KindBadFlag, 1, 1},
    '{KindZeroIn, 1, 0}, '{KindZeroIn, 1, 1}, '{KindTrunc, 1, 1},
    '{KindShort, 0, 0}
  };

  task automatic build_dir(input dir_row_t row);
    int cut;
    case (row.kind)
      KindZeroTx: begin
        put_rand(80); put_var(0, $urandom_range(0, 3)); put_rand(3);
      end
      KindBadFlag: begin
        put_rand(80); put_var(1, 0); put_rand(4);
        blk_q.push_back(8'h00); blk_q.push_back(8'h02); put_rand(5);
      end
      KindZeroIn: begin
        put_rand(80); put_var(1, 0); put_rand(4);
        if (row.wmode != 0) begin
          blk_q.push_back(8'h00); blk_q.push_back(8'h01);
        end
        put_var(0, 1); put_rand(2);
      end
      KindTrunc: begin
        build_block(1, 1);
        cut = $urandom_range(81, blk_q.size() - 2);
        while (blk_q.size() > cut) void'(blk_q.pop_back());
      end
      KindShort: put_rand(1);
      default: build_block(row.ntx, row.wmode);
    endcase
  endtask

  initial begin
    int sent;
    int pick;
    rst_n = 1'b0; in_push = 1'b0; in_byte = '0; in_block_end = 1'b0;
    out_pop = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; n_err = 0; idle_cnt = 0; stop_pop = 1'b0;
    cap_q = CapReset;
    clear_block();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed blocks with reset capacity
    sent = 0;
    foreach (dir_tab[i]) begin
      build_dir(dir_tab[i]);
      sent += blk_q.size();
      send_block();
    end
    drain();

    // Random phases across capacity settings, extremes first
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_cap(24'd0);
        1: write_cap(24'd1);
        2: write_cap(24'hffffff);
        default: write_cap(24'($urandom_range(60, 400)));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) build_block($urandom_range(1, 2), 2);
      else build_dir(dir_tab[$urandom_range(1, 6)]);
      sent += blk_q.size();
      send_block();
      drain();
      if (sent >= 1000 && p >= 1) break;
    end

    stop_pop = 1'b1;
    repeat (10) @(negedge clk);
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("segwit_block_witness_stripper test passed");
    end else begin
      $display("segwit_block_witness_stripper test failed");
    end
    $finish;
  end

endmodule
